>>> design/lvn_pkg.sv
// lvn_pkg: shared constants and types for the layered value noise unit
// no dependencies
package lvn_pkg;

   typedef logic [31:0] word_type;

   localparam int MAX_LAYERS_DEF = 8;
   localparam int COORD_BITS_DEF = 16;

   localparam int NOISE_W    = 17;
   localparam int SEED_W     = 16;
   localparam int LCNT_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SEED   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_LAYERS = CSR_IDX_W'(1);

   // lattice offsets
   localparam word_type SEED_MUL = 32'd985;
   localparam word_type X_STEP   = 32'd654321;
   localparam word_type Y_STEP   = 32'd984653;
   localparam word_type ROW_MUL  = 32'd123456;

   // integer hash
   localparam int       HASH_SHIFT = 13;
   localparam word_type HASH_MUL   = 32'd15731;
   localparam word_type HASH_ADD1  = 32'd789221;
   localparam word_type HASH_ADD2  = 32'd1376312589;
   localparam word_type HASH_MASK  = 32'h7fffffff;

   // corner is set when 255*(2^31-h) >= 129*2^31, i.e. h <= CORNER_LIM
   localparam longint   TWO31      = 64'd2147483648;
   localparam longint   CORNER_CUT = (129 * TWO31 + 254) / 255;
   localparam word_type CORNER_LIM = 32'(TWO31 - CORNER_CUT);

   localparam logic [NOISE_W-1:0] NOISE_ONE = NOISE_W'(65536);
   localparam int FRAC_OUT = 16;

endpackage

>>> design/lvn_channels.sv
// lvn_channels: valid/ready channel interfaces of the noise unit
// depends on lvn_pkg
interface lvn_req_if #(parameter int COORD_BITS = lvn_pkg::COORD_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] coord_x;
   logic [COORD_BITS-1:0] coord_y;
   modport source (output valid, coord_x, coord_y, input ready);
   modport sink   (input valid, coord_x, coord_y, output ready);
endinterface

interface lvn_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lvn_pkg::NOISE_W-1:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

interface lvn_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lvn_pkg::CSR_IDX_W-1:0]  index;
   logic [lvn_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/layered_value_noise_unit.sv
// layered_value_noise_unit: pipelined fractal value noise, one pixel per beat
// depends on lvn_pkg and lvn_channels
//
//   channel  dir  beat contents
//   req      in   coord_x, coord_y
//   rsp      out  noise_value (unsigned q1.16)
//   csr      in   index, data (0 seed, 1 layer count)
//
// one beat per cycle while rsp is not stalled; the pipeline depth is set by the hash multiplier
// chain and the 4-bit-per-stage divider by 2^n-1
// all stages move together; a stalled rsp holds every stage, nothing is dropped
// reset clears valid bits and the registers (seed 0, layer count 1); csr always ready
module layered_value_noise_unit #(
   parameter int MAX_LAYERS = lvn_pkg::MAX_LAYERS_DEF,
   parameter int COORD_BITS = lvn_pkg::COORD_BITS_DEF
) (
   input logic clock,
   input logic reset,
   lvn_req_if.sink   req_chan,
   lvn_rsp_if.source rsp_chan,
   lvn_csr_if.sink   csr_chan
);

   localparam int LN_W    = $clog2(MAX_LAYERS + 1);
   localparam int FR_W    = MAX_LAYERS + 1;          // holds 2^L
   localparam int RES_W   = 2 * FR_W;
   localparam int SUM_W   = 3 * MAX_LAYERS;
   localparam int T_W     = lvn_pkg::FRAC_OUT + MAX_LAYERS;
   localparam int DIV_PER = 4;
   localparam int DS      = (T_W + DIV_PER - 1) / DIV_PER;
   localparam int NV      = 9 + DS;                  // valid bits before output reg

   // config registers
   lvn_pkg::word_type         seed_off_ff;
   logic [lvn_pkg::LCNT_W-1:0] lcnt_ff;

   // pipeline valid bits
   logic [NV-1:0] v_ff;
   logic          rsp_valid_ff;
   logic          adv;

   // stage payloads
   logic [COORD_BITS-1:0] x_ff [7];
   logic [COORD_BITS-1:0] y_ff [7];
   logic [LN_W-1:0]       n_ff [9 + DS];

   lvn_pkg::word_type kb2_ff [MAX_LAYERS];
   lvn_pkg::word_type k3_ff  [MAX_LAYERS][4];
   lvn_pkg::word_type sq3_ff [MAX_LAYERS][4];
   lvn_pkg::word_type k4_ff  [MAX_LAYERS][4];
   lvn_pkg::word_type t4_ff  [MAX_LAYERS][4];
   logic [30:0]       h5_ff  [MAX_LAYERS][4];
   logic [FR_W-1:0]   top6_ff [MAX_LAYERS];
   logic [FR_W-1:0]   bot6_ff [MAX_LAYERS];
   logic [SUM_W-1:0]  res7_ff [MAX_LAYERS];
   logic [SUM_W-1:0]  sum8_ff;
   logic [T_W-1:0]    tq_ff  [DS + 1];
   logic [MAX_LAYERS-1:0] rem_ff [DS + 1];
   logic [lvn_pkg::NOISE_W-1:0] rsp_ff;

   // next values
   logic [LN_W-1:0]       n_in;
   lvn_pkg::word_type     kb2_in [MAX_LAYERS];
   lvn_pkg::word_type     k3_in  [MAX_LAYERS][4];
   lvn_pkg::word_type     sq3_in [MAX_LAYERS][4];
   lvn_pkg::word_type     t4_in  [MAX_LAYERS][4];
   logic [30:0]           h5_in  [MAX_LAYERS][4];
   logic [FR_W-1:0]       top6_in [MAX_LAYERS];
   logic [FR_W-1:0]       bot6_in [MAX_LAYERS];
   logic [SUM_W-1:0]      res7_in [MAX_LAYERS];
   logic [SUM_W-1:0]      sum8_in;
   logic [T_W-1:0]        t9_in;
   logic [T_W-1:0]        tq_in  [DS];
   logic [MAX_LAYERS-1:0] rem_in [DS];
   logic [lvn_pkg::NOISE_W-1:0] rsp_in;

   // whole pipe moves when the output register is free or drained
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.noise_value = rsp_ff;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_off_ff <= '0;
         lcnt_ff     <= lvn_pkg::LCNT_W'(1);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            lvn_pkg::REG_SEED: begin
               seed_off_ff <= 32'(csr_chan.data) * lvn_pkg::SEED_MUL;
            end
            lvn_pkg::REG_LAYERS: begin
               lcnt_ff <= csr_chan.data[lvn_pkg::LCNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective layer count, clamped to 1..MAX_LAYERS
   always_comb begin
      if (lcnt_ff == '0) begin
         n_in = LN_W'(1);
      end else if (32'(lcnt_ff) > MAX_LAYERS) begin
         n_in = LN_W'(MAX_LAYERS);
      end else begin
         n_in = LN_W'(lcnt_ff);
      end
   end

   // stage 2: base lattice key per layer
   always_comb begin
      lvn_pkg::word_type cx;
      lvn_pkg::word_type cy;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         cx = 32'(x_ff[0] >> (l + 1)) + seed_off_ff + 32'(l + 1) * lvn_pkg::X_STEP;
         cy = 32'(y_ff[0] >> (l + 1)) + 32'(l + 1) * lvn_pkg::Y_STEP;
         kb2_in[l] = cx + cy * lvn_pkg::ROW_MUL;
      end
   end

   // stage 3: corner keys, shift-xor, square
   always_comb begin
      lvn_pkg::word_type kr;
      lvn_pkg::word_type off;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         for (int c = 0; c < 4; c++) begin
            off = ((c % 2) == 1 ? 32'd1 : 32'd0) + ((c / 2) == 1 ? lvn_pkg::ROW_MUL : 32'd0);
            kr = kb2_ff[l] + off;
            k3_in[l][c]  = (kr << lvn_pkg::HASH_SHIFT) ^ kr;
            sq3_in[l][c] = k3_in[l][c] * k3_in[l][c];
         end
      end
   end

   // stages 4 and 5: hash polynomial
   always_comb begin
      lvn_pkg::word_type hv;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         for (int c = 0; c < 4; c++) begin
            t4_in[l][c] = sq3_ff[l][c] * lvn_pkg::HASH_MUL + lvn_pkg::HASH_ADD1;
            hv = (k4_ff[l][c] * t4_ff[l][c] + lvn_pkg::HASH_ADD2) & lvn_pkg::HASH_MASK;
            h5_in[l][c] = hv[30:0];
         end
      end
   end

   // stage 6: corner bits and horizontal blend
   always_comb begin
      logic [FR_W-1:0] s;
      logic [FR_W-1:0] fx;
      logic [3:0]      p;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         s  = FR_W'(1) << (l + 1);
         fx = FR_W'(32'(x_ff[4]) & (32'(s) - 32'd1));
         for (int c = 0; c < 4; c++) begin
            p[c] = (32'(h5_ff[l][c]) <= lvn_pkg::CORNER_LIM);
         end
         top6_in[l] = (p[0] ? s - fx : '0) + (p[1] ? fx : '0);
         bot6_in[l] = (p[2] ? s - fx : '0) + (p[3] ? fx : '0);
      end
   end

   // stage 7: vertical blend and layer weight
   always_comb begin
      logic [FR_W-1:0]  s;
      logic [FR_W-1:0]  fy;
      logic [RES_W-1:0] r;
      int               sh;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         s  = FR_W'(1) << (l + 1);
         fy = FR_W'(32'(y_ff[5]) & (32'(s) - 32'd1));
         r  = RES_W'(top6_ff[l]) * RES_W'(s - fy) + RES_W'(bot6_ff[l]) * RES_W'(fy);
         sh = 2 * int'(n_ff[5]) - (l + 1) - 1;
         if ((l + 1) <= int'(n_ff[5])) begin
            res7_in[l] = SUM_W'(r) << sh;
         end else begin
            res7_in[l] = '0;
         end
      end
   end

   // stage 8: layer sum; stage 9: drop the 2^(2n) scale
   always_comb begin
      logic [SUM_W+lvn_pkg::FRAC_OUT-1:0] wide;
      sum8_in = '0;
      for (int l = 0; l < MAX_LAYERS; l++) begin
         sum8_in = sum8_in + res7_ff[l];
      end
      wide  = {sum8_ff, lvn_pkg::FRAC_OUT'(0)} >> (2 * int'(n_ff[7]));
      t9_in = wide[T_W-1:0];
   end

   // divider stages: restoring division by 2^n-1, DIV_PER bits per stage
   always_comb begin
      logic [T_W-1:0]        tq;
      logic [MAX_LAYERS:0]   r;
      logic [MAX_LAYERS:0]   d;
      for (int s = 0; s < DS; s++) begin
         tq = tq_ff[s];
         r  = {1'b0, rem_ff[s]};
         d  = (MAX_LAYERS + 1)'((32'd1 << n_ff[8 + s]) - 32'd1);
         for (int j = 0; j < DIV_PER; j++) begin
            if (s * DIV_PER + j < T_W) begin
               r  = {r[MAX_LAYERS-1:0], tq[T_W-1]};
               tq = tq << 1;
               if (r >= d) begin
                  r     = r - d;
                  tq[0] = 1'b1;
               end
            end
         end
         tq_in[s]  = tq;
         rem_in[s] = r[MAX_LAYERS-1:0];
      end
      // saturate to 1.0
      if (tq_ff[DS] > T_W'(lvn_pkg::NOISE_ONE)) begin
         rsp_in = lvn_pkg::NOISE_ONE;
      end else begin
         rsp_in = tq_ff[DS][lvn_pkg::NOISE_W-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[NV-2:0], req_chan.valid};
         rsp_valid_ff <= v_ff[NV-1];
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= req_chan.coord_x;
         y_ff[0] <= req_chan.coord_y;
         n_ff[0] <= n_in;
         for (int i = 1; i < 7; i++) begin
            x_ff[i] <= x_ff[i-1];
            y_ff[i] <= y_ff[i-1];
         end
         for (int i = 1; i < 9 + DS; i++) begin
            n_ff[i] <= n_ff[i-1];
         end
         kb2_ff  <= kb2_in;
         k3_ff   <= k3_in;
         sq3_ff  <= sq3_in;
         k4_ff   <= k3_ff;
         t4_ff   <= t4_in;
         h5_ff   <= h5_in;
         top6_ff <= top6_in;
         bot6_ff <= bot6_in;
         res7_ff <= res7_in;
         sum8_ff <= sum8_in;
         tq_ff[0]  <= t9_in;
         rem_ff[0] <= '0;
         for (int s = 0; s < DS; s++) begin
            tq_ff[s+1]  <= tq_in[s];
            rem_ff[s+1] <= rem_in[s];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> bench/layered_value_noise_unit_tb.sv
// layered_value_noise_unit_tb: self-checking bench for the layered value noise unit
// predicts each pixel's noise value and compares it with every rsp beat
// depends on lvn_pkg, lvn_channels and layered_value_noise_unit
module layered_value_noise_unit_tb;

   localparam int N_RANDOM  = 700;
   localparam int LATENCY   = 16;
   localparam int CYCLE_CAP = 400000;

   // scoreboard: the configuration copy and the queue of expected noise values
   class noise_scoreboard;
      logic [lvn_pkg::SEED_W-1:0]  seed_reg;
      logic [lvn_pkg::LCNT_W-1:0]  layer_reg;
      logic [lvn_pkg::NOISE_W-1:0] pending[$];
      int errors;

      function void clear();
         seed_reg = '0;
         layer_reg = lvn_pkg::LCNT_W'(1);
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [lvn_pkg::CSR_IDX_W-1:0] idx,
                              logic [lvn_pkg::CSR_DATA_W-1:0] val);
         if (idx == lvn_pkg::REG_SEED) seed_reg = val;
         else if (idx == lvn_pkg::REG_LAYERS) layer_reg = lvn_pkg::LCNT_W'(val);
      endfunction

      static function bit corner_set(logic [31:0] cx, logic [31:0] cy);
         logic [31:0] k;
         logic [31:0] h;
         logic [63:0] lhs;
         k = cx + cy * 32'd123456;
         k = (k << 13) ^ k;
         h = (k * (k * k * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
         lhs = 64'd255 * ((64'd1 << 31) - {32'd0, h});
         return lhs >= 64'd129 * (64'd1 << 31);
      endfunction

      function logic [lvn_pkg::NOISE_W-1:0] noise_of(logic [15:0] px, logic [15:0] py);
         int unsigned n;
         logic [63:0] sum, den, val, s, fx, fy, top, bot, res;
         logic [31:0] cx, cy;
         n = layer_reg;
         if (n < 1) n = 1;
         if (n > lvn_pkg::MAX_LAYERS_DEF) n = lvn_pkg::MAX_LAYERS_DEF;
         sum = 0;
         for (int lay = 1; lay <= n; lay++) begin
            s = 64'd1 << lay;
            fx = px & (s - 1);
            fy = py & (s - 1);
            cx = 32'(px >> lay) + 32'(seed_reg) * 32'd985 + 32'(lay) * 32'd654321;
            cy = 32'(py >> lay) + 32'(lay) * 32'd984653;
            top = corner_set(cx, cy) * (s - fx) + corner_set(cx + 1, cy) * fx;
            bot = corner_set(cx, cy + 1) * (s - fx) + corner_set(cx + 1, cy + 1) * fx;
            res = top * (s - fy) + bot * fy;
            sum += res << (2 * n - lay - 1);
         end
         den = ((64'd1 << n) - 1) << (2 * n);
         val = (sum << 16) / den;
         if (val > 65536) val = 65536;
         return lvn_pkg::NOISE_W'(val);
      endfunction

      function void note_pixel(logic [15:0] px, logic [15:0] py);
         pending.push_back(noise_of(px, py));
      endfunction

      function void check_noise(logic [lvn_pkg::NOISE_W-1:0] got);
         logic [lvn_pkg::NOISE_W-1:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected noise beat, expected none, actual %0d", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   lvn_req_if req_chan ();
   lvn_rsp_if rsp_chan ();
   lvn_csr_if csr_chan ();
   noise_scoreboard board;
   bit quiet_phase = 0;
   int unsigned cycles = 0;

   always #6 clock = ~clock;

   layered_value_noise_unit DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // rsp side: check on the rising edge, stall in bursts at the falling edge
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) board.check_noise(rsp_chan.noise_value);
   end
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= 1'b1;
   end

   // one pixel beat; an idle burst may come first, valid stays up for the next beat
   task automatic send_pixel(logic [15:0] px, logic [15:0] py);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.coord_x <= px;
      req_chan.coord_y <= py;
      do @(posedge clock); while (!req_chan.ready);
      board.note_pixel(px, py);
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      @(negedge clock);
   endtask

   // register write, only with the pipeline empty
   task automatic write_csr(logic [lvn_pkg::CSR_IDX_W-1:0] idx,
                            logic [lvn_pkg::CSR_DATA_W-1:0] val);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      board.write_reg(idx, val);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic random_pixel();
      logic [15:0] px, py;
      case ($urandom_range(0, 3))
         0: begin px = 16'($urandom_range(0, 255)); py = 16'($urandom_range(0, 255)); end
         1: begin px = 16'hffff - 16'($urandom_range(0, 15)); py = 16'($urandom); end
         default: begin px = 16'($urandom); py = 16'($urandom); end
      endcase
      send_pixel(px, py);
   endtask

   initial begin
      board = new();
      board.clear();
      req_chan.valid = 0; req_chan.coord_x = 0; req_chan.coord_y = 0;
      csr_chan.valid = 0; csr_chan.index = lvn_pkg::REG_SEED; csr_chan.data = 0;
      rsp_chan.ready = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners of the coordinate space and one inner point at reset settings
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hffff, 16'hffff);
      send_pixel(16'hffff, 16'h0000);
      send_pixel(16'h0000, 16'hffff);
      send_pixel(16'h5555, 16'haaaa);
      // zero layer count acts as one layer
      write_csr(lvn_pkg::REG_LAYERS, 16'd0);
      send_pixel(16'h1234, 16'h8765);
      send_pixel(16'hffff, 16'h0001);
      // count above the maximum saturates, upper data bits ignored
      write_csr(lvn_pkg::REG_LAYERS, 16'hfff9);
      send_pixel(16'h0000, 16'h0000);
      send_pixel(16'hffff, 16'hffff);
      write_csr(lvn_pkg::REG_LAYERS, 16'd15);
      send_pixel(16'h00ff, 16'hff00);
      write_csr(lvn_pkg::REG_SEED, 16'hffff);
      write_csr(lvn_pkg::REG_LAYERS, 16'd8);
      send_pixel(16'hf0f0, 16'h0f0f);
      send_pixel(16'hffff, 16'hffff);
      // index beyond the register list is ignored
      write_csr(lvn_pkg::CSR_IDX_W'(3), 16'd3);
      write_csr(lvn_pkg::CSR_IDX_W'(2), 16'd2);
      send_pixel(16'h0001, 16'h0002);

      // random phases across seeds and layer counts
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(lvn_pkg::REG_SEED, ph == 0 ? 16'd0 : 16'($urandom));
         write_csr(lvn_pkg::REG_LAYERS, ph < 8 ? 16'(ph + 1) : 16'($urandom_range(0, 15)));
         if (ph == 9) quiet_phase = 1;
         for (int i = 0; i < N_RANDOM / 10; i++) begin
            random_pixel();
            // sender holds off until the pipeline has emptied
            if (ph == 4 && i == 20) begin
               req_chan.valid <= 1'b0;
               while (board.pending.size() != 0) @(posedge clock);
               @(negedge clock);
            end
         end
      end

      drain();
      if (board.errors == 0 && board.pending.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
